/* hdl/matrix_row_operation_engine_macros.svh */
// Assertion macros shared by the matrix row operation engine.
`ifndef MATRIX_ROW_OPERATION_ENGINE_MACROS_SVH
`define MATRIX_ROW_OPERATION_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MROE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MROE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mroe_pkg.sv */
// Package with sizes, codes and types of the matrix row operation engine.
package mroe_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 32;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  localparam int ROWS_REG_W = 5;
  localparam int COLS_REG_W = 6;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 5'd16;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;

  localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SWAP  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ADD   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SCALE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_ROW_ERR = 2'd1;
  localparam logic [STAT_W-1:0] ST_COL_ERR = 2'd2;

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } ram_rd_t;

endpackage

/* hdl/mroe_if.sv */
// Command and response channel interfaces of the matrix row operation engine.
interface mroe_cmd_if import mroe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [ROW_W-1:0]         row_a;
  logic [ROW_W-1:0]         row_b;
  logic [COL_W-1:0]         col_index;
  logic signed [DATA_W-1:0] element_value;
  logic signed [DATA_W-1:0] factor;

  modport source (output valid, action, row_a, row_b, col_index, element_value, factor,
                  input ready);
  modport sink (input valid, action, row_a, row_b, col_index, element_value, factor,
                output ready);
endinterface

interface mroe_rsp_if import mroe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic                     saturated;

  modport source (output valid, read_value, status, saturated, input ready);
  modport sink (input valid, read_value, status, saturated, output ready);
endinterface

/* hdl/matrix_row_operation_engine.sv */
// Top level of the matrix row operation engine: sequencer, pipeline and ports.
// Write and read items pass through S_ELEM to S_DONE; items with index errors go straight to S_DONE.
// Add scaled row and scale row stream one column per cycle over the columns in use.
// Swap rows needs two memory writes per column and covers all MAX_COLS columns.
// The next item is accepted from the cycle after its result loads, so one item is in flight at a time.
// After reset a sweep zeroes all 512 memory words while cmd.ready stays low.
`include "matrix_row_operation_engine_macros.svh"

module matrix_row_operation_engine import mroe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  mroe_cmd_if.sink              cmd,
  mroe_rsp_if.source            rsp,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ELEM  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state;
  logic [ADDR_W-1:0]       clr_addr;
  logic [ROWS_REG_W-1:0]   rows_used;
  logic [COLS_REG_W-1:0]   cols_used;
  logic [RCNT_W-1:0]       nr;
  logic [CCNT_W-1:0]       nc;

  logic [ACT_W-1:0]         act;
  logic [ROW_W-1:0]         ra;
  logic [ROW_W-1:0]         rb;
  logic [COL_W-1:0]         col;
  logic [DATA_W-1:0]        value;
  logic signed [DATA_W-1:0] factor;
  logic [STAT_W-1:0]        status_r;
  logic                     sat_acc;

  logic                     accept;
  logic                     ra_ok;
  logic                     rb_ok;
  logic                     col_ok;
  logic [STAT_W-1:0]        status_next;
  logic [2:0]               work_state;

  logic                     is_swap;
  logic                     is_add;
  logic [CCNT_W-1:0]        col_cnt;
  logic [CCNT_W-1:0]        limit;
  logic                     phase;
  logic                     issue;
  logic                     p1_valid;
  logic [COL_W-1:0]         p1_col;
  logic                     p2_valid;
  logic [COL_W-1:0]         p2_col;
  logic [DATA_W-1:0]        p2_qa;
  logic [DATA_W-1:0]        p2_qb;
  logic                     p3_valid;
  logic [COL_W-1:0]         p3_col;
  logic [DATA_W-1:0]        p3_data;

  ram_wr_t                  wr;
  ram_rd_t                  rd;
  logic [DATA_W-1:0]        q_a;
  logic [DATA_W-1:0]        q_b;
  logic signed [DATA_W-1:0] unit_result;
  logic                     unit_sat;
  logic                     out_load;

  // Register values outside the legal range are clamped to it.
  always_comb begin
    if (rows_used == '0) begin
      nr = RCNT_W'(1);
    end else if (32'(rows_used) > MAX_ROWS) begin
      nr = RCNT_W'(MAX_ROWS);
    end else begin
      nr = RCNT_W'(rows_used);
    end
    if (cols_used == '0) begin
      nc = CCNT_W'(1);
    end else if (32'(cols_used) > MAX_COLS) begin
      nc = CCNT_W'(MAX_COLS);
    end else begin
      nc = CCNT_W'(cols_used);
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  // A row error is reported before a column error.
  always_comb begin
    ra_ok       = RCNT_W'(cmd.row_a) < nr;
    rb_ok       = RCNT_W'(cmd.row_b) < nr;
    col_ok      = CCNT_W'(cmd.col_index) < nc;
    status_next = ST_OK;
    work_state  = S_DONE;
    unique case (cmd.action)
      ACT_WRITE, ACT_READ: begin
        if (!ra_ok) begin
          status_next = ST_ROW_ERR;
        end else if (!col_ok) begin
          status_next = ST_COL_ERR;
        end else begin
          work_state = S_ELEM;
        end
      end
      ACT_SWAP, ACT_ADD: begin
        if (!ra_ok || !rb_ok) begin
          status_next = ST_ROW_ERR;
        end else begin
          work_state = S_RUN;
        end
      end
      ACT_SCALE: begin
        if (!ra_ok) begin
          status_next = ST_ROW_ERR;
        end else begin
          work_state = S_RUN;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign is_swap = (act == ACT_SWAP);
  assign is_add  = (act == ACT_ADD);
  assign limit   = is_swap ? CCNT_W'(MAX_COLS) : nc;
  assign issue   = (state == S_RUN) && (col_cnt < limit) && !phase;
  assign out_load = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= ROWS_RESET;
      cols_used <= COLS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS: rows_used <= cfg_data[ROWS_REG_W-1:0];
        REG_COLS: cols_used <= cfg_data[COLS_REG_W-1:0];
        default:  rows_used <= rows_used;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      col_cnt  <= '0;
      phase    <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid && is_swap;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          col_cnt <= '0;
          phase   <= 1'b0;
          if (accept) begin
            state <= work_state;
          end
        end
        S_ELEM: begin
          state <= S_DONE;
        end
        S_RUN: begin
          if (issue) begin
            col_cnt <= col_cnt + 1'b1;
          end
          // Swap issues only while phase is low and toggles phase, so that both rows get written.
          phase <= is_swap ? !phase : 1'b0;
          if (col_cnt == limit && !p1_valid && !p2_valid && !p3_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= cmd.action;
      ra       <= cmd.row_a;
      rb       <= cmd.row_b;
      col      <= cmd.col_index;
      value    <= cmd.element_value;
      factor   <= cmd.factor;
      status_r <= status_next;
    end
    if (issue) begin
      p1_col <= col_cnt[COL_W-1:0];
    end
    if (p1_valid) begin
      p2_col <= p1_col;
      p2_qa  <= q_a;
      p2_qb  <= q_b;
    end
    if (p2_valid) begin
      p3_col  <= p2_col;
      p3_data <= p2_qa;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_acc <= 1'b0;
    end else if (accept) begin
      sat_acc <= 1'b0;
    end else if (p2_valid && !is_swap) begin
      sat_acc <= sat_acc || unit_sat;
    end
  end

  // One write port: clearing sweep, element write, row result, second swap write.
  always_comb begin
    wr.en   = 1'b0;
    wr.addr = {ra, col};
    wr.data = value;
    priority if (state == S_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr;
      wr.data = '0;
    end else if (state == S_ELEM && act == ACT_WRITE) begin
      wr.en = 1'b1;
    end else if (p2_valid) begin
      wr.en   = 1'b1;
      wr.addr = {ra, p2_col};
      wr.data = is_swap ? p2_qb : unit_result;
    end else if (p3_valid) begin
      wr.en   = 1'b1;
      wr.addr = {rb, p3_col};
      wr.data = p3_data;
    end else begin
      wr.en = 1'b0;
    end
  end

  always_comb begin
    rd.en     = issue || (state == S_ELEM && act == ACT_READ);
    rd.addr_a = issue ? {ra, col_cnt[COL_W-1:0]} : {ra, col};
    rd.addr_b = {rb, col_cnt[COL_W-1:0]};
  end

  mroe_matrix_ram u_ram (
    .clk (clk),
    .wr  (wr),
    .rd  (rd),
    .q_a (q_a),
    .q_b (q_b)
  );

  mroe_mul_unit u_mul (
    .clk      (clk),
    .load     (p1_valid),
    .factor   (factor),
    .operand  (is_add ? q_b : q_a),
    .dst      (p2_qa),
    .add_mode (is_add),
    .result   (unit_result),
    .sat      (unit_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.read_value <= (act == ACT_READ && status_r == ST_OK) ? q_a : '0;
      rsp.status     <= status_r;
      rsp.saturated  <= sat_acc;
    end
  end

  `MROE_ASSERT_IMP(a_idle_pipe_empty, clk, rst, cmd.ready,
                   !p1_valid && !p2_valid && !p3_valid, "item accepted with work in flight")
  `MROE_ASSERT_IMP(a_single_row_write, clk, rst, p2_valid, !p3_valid,
                   "row result and swap write collide")
  `MROE_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !cmd.ready,
                   "ready stayed high after an item was accepted")
  `MROE_ASSERT_IMP(a_sat_only_ok, clk, rst, rsp.valid && rsp.status != ST_OK,
                   !rsp.saturated, "saturation flagged on a failed item")

endmodule

/* hdl/mroe_matrix_ram.sv */
// Coefficient memory: one write port and two registered read ports.
module mroe_matrix_ram import mroe_pkg::*; (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  ram_rd_t           rd,
  output logic [DATA_W-1:0] q_a,
  output logic [DATA_W-1:0] q_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      q_a <= mem[rd.addr_a];
      q_b <= mem[rd.addr_b];
    end
  end

endmodule

/* hdl/mroe_mul_unit.sv */
// Shared Q16.16 multiply unit with saturation and optional saturating add.
module mroe_mul_unit import mroe_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] factor,
  input  logic signed [DATA_W-1:0] operand,
  input  logic signed [DATA_W-1:0] dst,
  input  logic                     add_mode,
  output logic signed [DATA_W-1:0] result,
  output logic                     sat
);

  logic signed [2*DATA_W-1:0] prod;
  logic [DATA_W-FRAC_W:0]     prod_hi;
  logic                       prod_ovf;
  logic signed [DATA_W-1:0]   prod_q;
  logic signed [DATA_W:0]     sum;
  logic                       sum_ovf;
  logic signed [DATA_W-1:0]   sum_q;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= factor * operand;
    end
  end

  // The shifted product fits when every bit above its sign matches it.
  always_comb begin
    prod_hi  = prod[2*DATA_W-1:DATA_W+FRAC_W-1];
    prod_ovf = !((&prod_hi) || !(|prod_hi));
    if (prod_ovf) begin
      prod_q = prod[2*DATA_W-1] ? Q_MIN : Q_MAX;
    end else begin
      prod_q = prod[DATA_W+FRAC_W-1:FRAC_W];
    end
    sum     = {dst[DATA_W-1], dst} + {prod_q[DATA_W-1], prod_q};
    sum_ovf = sum[DATA_W] ^ sum[DATA_W-1];
    if (sum_ovf) begin
      sum_q = sum[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      sum_q = sum[DATA_W-1:0];
    end
    result = add_mode ? sum_q : prod_q;
    sat    = prod_ovf || (add_mode && sum_ovf);
  end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the matrix row operation engine with its own matrix predictor.
`timescale 1ns / 100ps

module tb_top;
  import mroe_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;
  localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_HALF = 32'h0000_8000;
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  localparam int IDLE_LIMIT = 6000;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_OPS = 107;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ROW_W-1:0]  row_a;
    logic [ROW_W-1:0]  row_b;
    logic [COL_W-1:0]  col_index;
    logic [DATA_W-1:0] element_value;
    logic [DATA_W-1:0] factor;
  } row_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [STAT_W-1:0] status;
    logic              saturated;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  mroe_cmd_if cmd_if ();
  mroe_rsp_if rsp_if ();

  matrix_row_operation_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .rsp       (rsp_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: the matrix and the register settings as the block should hold them.
  logic [DATA_W-1:0]     coef_store [MAX_ROWS][MAX_COLS];
  logic [ROWS_REG_W-1:0] rows_setting = ROWS_RESET;
  logic [COLS_REG_W-1:0] cols_setting = COLS_RESET;
  logic                  op_sat;

  row_op_t   pending_row_ops[$];
  response_t expected_responses[$];

  int mismatch_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_requests = 0;
  int stall_served = 0;
  int hold_left = 0;
  int window_left = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  function automatic int eff_rows();
    if (rows_setting == 0) return 1;
    if (rows_setting > MAX_ROWS) return MAX_ROWS;
    return int'(rows_setting);
  endfunction

  function automatic int eff_cols();
    if (cols_setting == 0) return 1;
    if (cols_setting > MAX_COLS) return MAX_COLS;
    return int'(cols_setting);
  endfunction

  function automatic logic [DATA_W-1:0] clamp_q(longint v);
    if (v > Q_HI) begin
      op_sat = 1'b1;
      return Q_MAX;
    end
    if (v < Q_LO) begin
      op_sat = 1'b1;
      return Q_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // The arithmetic shift of the exact product rounds toward minus infinity.
  function automatic logic [DATA_W-1:0] q_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return clamp_q(p >>> FRAC_W);
  endfunction

  function automatic response_t apply_row_op(row_op_t op);
    response_t r;
    int nr;
    int nc;
    logic [DATA_W-1:0] t;
    r = '0;
    op_sat = 1'b0;
    nr = eff_rows();
    nc = eff_cols();
    case (op.action)
      ACT_WRITE, ACT_READ: begin
        if (op.row_a >= nr) r.status = ST_ROW_ERR;
        else if (op.col_index >= nc) r.status = ST_COL_ERR;
        else if (op.action == ACT_WRITE) coef_store[op.row_a][op.col_index] = op.element_value;
        else r.read_value = coef_store[op.row_a][op.col_index];
      end
      ACT_SWAP: begin
        if (op.row_a >= nr || op.row_b >= nr) r.status = ST_ROW_ERR;
        else if (op.row_a != op.row_b) begin
          // Swap moves every column of the store, not only the ones in use.
          for (int c = 0; c < MAX_COLS; c++) begin
            t = coef_store[op.row_a][c];
            coef_store[op.row_a][c] = coef_store[op.row_b][c];
            coef_store[op.row_b][c] = t;
          end
        end
      end
      ACT_ADD: begin
        if (op.row_a >= nr || op.row_b >= nr) r.status = ST_ROW_ERR;
        else begin
          for (int c = 0; c < nc; c++)
            coef_store[op.row_a][c] = clamp_q(longint'($signed(coef_store[op.row_a][c])) +
                longint'($signed(q_mul(op.factor, coef_store[op.row_b][c]))));
        end
      end
      ACT_SCALE: begin
        if (op.row_a >= nr) r.status = ST_ROW_ERR;
        else begin
          for (int c = 0; c < nc; c++)
            coef_store[op.row_a][c] = q_mul(op.factor, coef_store[op.row_a][c]);
        end
      end
      default: ;
    endcase
    r.saturated = op_sat;
    return r;
  endfunction

  function automatic row_op_t make_op(logic [ACT_W-1:0] action, int ra, int rb, int col,
                                      logic [DATA_W-1:0] value, logic [DATA_W-1:0] factor);
    row_op_t op;
    op.action = action;
    op.row_a = ROW_W'(ra);
    op.row_b = ROW_W'(rb);
    op.col_index = COL_W'(col);
    op.element_value = value;
    op.factor = factor;
    return op;
  endfunction

  function automatic logic [DATA_W-1:0] corner_q();
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  // Mostly in-range indices so the row operations do real work; the rest probes the errors.
  function automatic row_op_t random_op();
    row_op_t op;
    int pick;
    int nr;
    int nc;
    nr = eff_rows();
    nc = eff_cols();
    pick = $urandom_range(0, 99);
    if (pick < 25) op.action = ACT_WRITE;
    else if (pick < 45) op.action = ACT_READ;
    else if (pick < 58) op.action = ACT_SWAP;
    else if (pick < 78) op.action = ACT_ADD;
    else if (pick < 93) op.action = ACT_SCALE;
    else op.action = ACT_W'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
    op.row_a = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(0, MAX_ROWS - 1))
                                            : ROW_W'($urandom_range(0, nr - 1));
    op.row_b = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(0, MAX_ROWS - 1))
                                            : ROW_W'($urandom_range(0, nr - 1));
    if ($urandom_range(0, 15) == 0) op.row_b = op.row_a;
    op.col_index = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(0, MAX_COLS - 1))
                                                : COL_W'($urandom_range(0, nc - 1));
    case ($urandom_range(0, 3))
      0, 1: op.element_value = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      2: op.element_value = $urandom;
      default: op.element_value = corner_q();
    endcase
    case ($urandom_range(0, 4))
      0, 1, 2: op.factor = $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      3: op.factor = $urandom;
      default: op.factor = corner_q();
    endcase
    return op;
  endfunction

  task automatic wait_for_drain();
    while (pending_row_ops.size() != 0 || expected_responses.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    if (idx == REG_ROWS) rows_setting = value[ROWS_REG_W-1:0];
    else cols_setting = value[COLS_REG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_shape(input int rows, input int cols);
    repeat (4) @(posedge clk);
    write_cfg(REG_ROWS, rows);
    write_cfg(REG_COLS, cols);
    @(negedge clk);
  endtask

  // Half the items, then a pause until every response is back, then the rest.
  task automatic run_random_phase(input int count);
    for (int i = 0; i < count / 2; i++) pending_row_ops.push_back(random_op());
    wait_for_drain();
    for (int i = count / 2; i < count; i++) pending_row_ops.push_back(random_op());
    wait_for_drain();
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready)
        expected_responses.push_back(apply_row_op(pending_row_ops.pop_front()));
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          cmd_if.valid <= 1'b0;
        end else if (pending_row_ops.size() > 0) begin
          cmd_if.valid <= 1'b1;
          cmd_if.action <= pending_row_ops[0].action;
          cmd_if.row_a <= pending_row_ops[0].row_a;
          cmd_if.row_b <= pending_row_ops[0].row_b;
          cmd_if.col_index <= pending_row_ops[0].col_index;
          cmd_if.element_value <= pending_row_ops[0].element_value;
          cmd_if.factor <= pending_row_ops[0].factor;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall rate changes per window; a request starts one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      hold_left <= 0;
      window_left <= 0;
      stall_pct <= 0;
      stall_served <= 0;
    end else begin
      if (stall_served != stall_requests) begin
        stall_served <= stall_requests;
        hold_left <= LONG_HOLD;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
      if (window_left == 0) begin
        window_left <= $urandom_range(20, 120);
        stall_pct <= $urandom_range(0, 1) ? 0 : $urandom_range(20, 90);
      end else begin
        window_left <= window_left - 1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    response_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_responses.size() == 0) begin
        $error("response with none expected: read_value %0d status %0d saturated %0d",
               rsp_if.read_value, rsp_if.status, rsp_if.saturated);
        mismatch_count++;
      end else begin
        want = expected_responses.pop_front();
        if (rsp_if.read_value !== want.read_value) begin
          $error("read_value expected %0d, got %0d", $signed(want.read_value),
                 rsp_if.read_value);
          mismatch_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status expected %0d, got %0d", want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.saturated !== want.saturated) begin
          $error("saturated expected %0d, got %0d", want.saturated, rsp_if.saturated);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int shape_rows[11] = '{4, 1, 0, 31, 16, 7, 17, 2, 12, 16, 3};
    int shape_cols[11] = '{8, 1, 0, 63, 32, 33, 5, 2, 20, 1, 32};
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_WRITE;
    cmd_if.row_a = '0;
    cmd_if.row_b = '0;
    cmd_if.col_index = '0;
    cmd_if.element_value = '0;
    cmd_if.factor = '0;
    rsp_if.ready = 1'b0;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++) coef_store[r][c] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Full matrix: corner values, saturation both ways, swaps and same-row operations.
    pending_row_ops.push_back(make_op(ACT_WRITE, 0, 0, 0, Q_MAX, '0));
    pending_row_ops.push_back(make_op(ACT_WRITE, 15, 0, 31, Q_MIN, '0));
    pending_row_ops.push_back(make_op(ACT_WRITE, 1, 0, 0, Q_ONE, '0));
    pending_row_ops.push_back(make_op(ACT_WRITE, 1, 0, 1, -Q_ONE, '0));
    pending_row_ops.push_back(make_op(ACT_WRITE, 2, 0, 0, 2 * Q_ONE, '0));
    pending_row_ops.push_back(make_op(ACT_READ, 0, 0, 0, '0, '0));
    pending_row_ops.push_back(make_op(ACT_READ, 15, 0, 31, '0, '0));
    pending_row_ops.push_back(make_op(ACT_ADD, 0, 1, 0, '0, 2 * Q_ONE));
    pending_row_ops.push_back(make_op(ACT_SCALE, 2, 0, 0, '0, Q_MIN));
    pending_row_ops.push_back(make_op(ACT_SCALE, 15, 0, 0, '0, Q_MAX));
    pending_row_ops.push_back(make_op(ACT_SWAP, 0, 15, 0, '0, '0));
    pending_row_ops.push_back(make_op(ACT_SWAP, 3, 3, 0, '0, '0));
    pending_row_ops.push_back(make_op(ACT_ADD, 1, 1, 0, '0, Q_HALF));
    pending_row_ops.push_back(make_op(ACT_READ, 1, 0, 1, '0, '0));
    pending_row_ops.push_back(make_op(ACT_READ, 15, 0, 0, '0, '0));
    pending_row_ops.push_back(make_op(ACT_READ, 0, 0, 31, '0, '0));
    wait_for_drain();

    // Reduced shape: index errors, row error ahead of column error, unknown actions.
    set_shape(shape_rows[0], shape_cols[0]);
    pending_row_ops.push_back(make_op(ACT_READ, 4, 0, 0, '0, '0));
    pending_row_ops.push_back(make_op(ACT_WRITE, 0, 0, 8, Q_ONE, '0));
    pending_row_ops.push_back(make_op(ACT_READ, 5, 0, 20, '0, '0));
    pending_row_ops.push_back(make_op(ACT_SWAP, 0, 9, 0, '0, '0));
    pending_row_ops.push_back(make_op(ACT_ADD, 12, 0, 0, '0, Q_ONE));
    pending_row_ops.push_back(make_op(ACT_ADD, 0, 12, 0, '0, Q_ONE));
    pending_row_ops.push_back(make_op(ACT_SCALE, 4, 0, 0, '0, Q_HALF));
    pending_row_ops.push_back(make_op(ACT_RESERVED_FIRST, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
    pending_row_ops.push_back(make_op(ACT_W'(ACT_RESERVED_FIRST + 1), $urandom, $urandom,
                                      $urandom, $urandom, $urandom));
    pending_row_ops.push_back(make_op(ACT_RESERVED_LAST, $urandom, $urandom, $urandom,
                                      $urandom, $urandom));
    pending_row_ops.push_back(make_op(ACT_READ, 3, 0, 7, '0, '0));
    wait_for_drain();

    // The first random phase opens with a long receiver hold-off so the block backs up.
    stall_requests <= stall_requests + 1;
    run_random_phase(PHASE_OPS);
    for (int i = 1; i < 11; i++) begin
      set_shape(shape_rows[i], shape_cols[i]);
      run_random_phase(PHASE_OPS);
    end

    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/mroe_pkg.sv
hdl/mroe_if.sv
hdl/mroe_matrix_ram.sv
hdl/mroe_mul_unit.sv
hdl/matrix_row_operation_engine.sv
dv/tb_top.sv
